### hw/rtl/lrp_pkg.sv
package lrp_pkg;

    localparam logic CHECK_CRC_RESET = 1'b1;
    localparam logic [31:0] MAX_LENGTH_RESET = 32'd1048576;
    localparam logic [31:0] MIN_LENGTH = 32'd21;
    localparam logic [31:0] CRC_POLY = 32'h82F63B78;

    localparam logic CFG_CHECK_CRC = 1'b0;
    localparam logic CFG_MAX_LENGTH = 1'b1;

    typedef enum logic [1:0]
    {
        KIND_KEY = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_SUMMARY = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [3:0]
    {
        ERR_NONE = 4'd0,
        ERR_HEADER_TRUNC = 4'd1,
        ERR_TOO_SHORT = 4'd2,
        ERR_TOO_LONG = 4'd3,
        ERR_RECORD_TRUNC = 4'd4,
        ERR_CRC = 4'd5,
        ERR_KEY_VARINT = 4'd6,
        ERR_VALUE_VARINT = 4'd7,
        ERR_OVERFLOW = 4'd8,
        ERR_TRAILING = 4'd9
    } err_t;

    typedef enum logic [1:0]
    {
        PH_KEY = 2'd0,
        PH_VALUE = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_SKIP = 2'd3
    } phase_t;

    typedef struct packed
    {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic [63:0] record_offset;
        logic [63:0] record_timestamp;
        logic [7:0] attribute_bits;
        logic key_absent;
        logic [31:0] key_length;
        logic [31:0] value_length;
        logic [3:0] error_code;
        logic last;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### hw/rtl/lrp_out_queue.sv
module lrp_out_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [1:0]          push_count,
    input  lrp_pkg::result_t    push_a,
    input  lrp_pkg::result_t    push_b,
    output logic                space_ok,
    output logic                out_valid,
    input  logic                out_ready,
    output lrp_pkg::result_t    out_item
);

    lrp_pkg::result_t slot_reg [4];
    logic [1:0] rd_reg;
    logic [1:0] wr_reg;
    logic [2:0] count_reg;
    logic pop;
    logic [2:0] push_n;

    assign out_valid = (count_reg != 3'd0);
    assign out_item = slot_reg[rd_reg];
    assign pop = out_valid && out_ready;
    assign push_n = push ? {1'b0, push_count} : 3'd0;
    assign space_ok = (count_reg <= 3'd2);

    always_ff @(posedge clk)
    begin
        if (push && push_count != 2'd0)
        begin
            slot_reg[wr_reg] <= push_a;
            if (push_count == 2'd2)
            begin
                slot_reg[wr_reg + 2'd1] <= push_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
            wr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_reg + push_n[1:0];
            if (pop)
            begin
                rd_reg <= rd_reg + 2'd1;
            end
            count_reg <= count_reg + push_n - {2'd0, pop};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 3'd4)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        push && push_count != 2'd0 |-> count_reg <= 3'd2)
        else $error("push without space");
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> count_reg == $past(count_reg) + $past(push_n) - 3'd1)
        else $error("count tracking");

endmodule

### hw/rtl/lrp_parse_core.sv
module lrp_parse_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [7:0]          b,
    input  logic                eob,
    input  logic                check_crc,
    input  logic [31:0]         max_len,
    output logic                stopped,
    output logic [1:0]          res_count,
    output lrp_pkg::result_t    res_a,
    output lrp_pkg::result_t    res_b
);

    logic [32:0] pos_reg, pos_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] scrc_reg, scrc_next;
    logic [31:0] rcrc_reg, rcrc_next;
    logic [63:0] off_reg, off_next;
    logic [63:0] ts_reg, ts_next;
    logic [7:0] attr_reg, attr_next;
    logic [63:0] acc_reg, acc_next;
    logic [6:0] sh_reg, sh_next;
    lrp_pkg::phase_t ph_reg, ph_next;
    logic [63:0] key_reg, key_next;
    logic [63:0] vc_reg, vc_next;
    logic [3:0] perr_reg, perr_next;
    logic stop_reg, stop_next;

    logic [32:0] total, rem;
    logic [63:0] kl, kl_cur, acc_or, rem64;
    logic [6:0] sh_add;
    logic endrec;
    lrp_pkg::result_t ra, rb;
    logic [1:0] n;
    logic [3:0] code;

    assign stopped = stop_reg;
    assign total = {1'b0, len_reg} + 33'd4;
    assign rem = total - (pos_reg + 33'd1);
    assign rem64 = {31'd0, rem};
    assign kl = (key_reg == 64'd0) ? 64'd0 : key_reg - 64'd1;
    assign endrec = (pos_reg + 33'd1 == total);
    assign acc_or = acc_reg | ({57'd0, b[6:0]} << sh_reg[5:0]);
    assign sh_add = sh_reg + 7'd7;

    function automatic lrp_pkg::result_t mk(input logic [1:0] k, input logic [7:0] pb,
                                            input logic [3:0] ec);
        lrp_pkg::result_t r;
        r = '0;
        r.kind = k;
        r.payload_byte = pb;
        r.error_code = ec;
        return r;
    endfunction

    always_comb
    begin
        pos_next = pos_reg;
        len_next = len_reg;
        scrc_next = scrc_reg;
        rcrc_next = rcrc_reg;
        off_next = off_reg;
        ts_next = ts_reg;
        attr_next = attr_reg;
        acc_next = acc_reg;
        sh_next = sh_reg;
        ph_next = ph_reg;
        key_next = key_reg;
        vc_next = vc_reg;
        perr_next = perr_reg;
        stop_next = stop_reg;
        ra = '0;
        rb = '0;
        n = 2'd0;
        code = lrp_pkg::ERR_NONE;
        kl_cur = kl;

        if (pos_reg >= 33'd8)
        begin
            rcrc_next = lrp_pkg::crc_byte(rcrc_reg, b);
        end
        if (pos_reg < 33'd4)
        begin
            len_next = len_reg | ({24'd0, b} << {pos_reg[1:0], 3'd0});
        end
        else if (pos_reg < 33'd8)
        begin
            scrc_next = scrc_reg | ({24'd0, b} << {pos_reg[1:0], 3'd0});
        end
        else if (pos_reg < 33'd16)
        begin
            off_next = off_reg | ({56'd0, b} << {pos_reg[2:0], 3'd0});
        end
        else if (pos_reg < 33'd24)
        begin
            ts_next = ts_reg | ({56'd0, b} << {pos_reg[2:0], 3'd0});
        end
        else if (pos_reg == 33'd24)
        begin
            attr_next = b;
        end
        else if (ph_reg == lrp_pkg::PH_KEY || ph_reg == lrp_pkg::PH_VALUE)
        begin
            acc_next = acc_or;
            if (!b[7])
            begin
                if (ph_reg == lrp_pkg::PH_KEY)
                begin
                    key_next = acc_or;
                    ph_next = lrp_pkg::PH_VALUE;
                end
                else
                begin
                    vc_next = acc_or;
                    ph_next = lrp_pkg::PH_PAYLOAD;
                    if (kl > rem64 || acc_or > rem64 - kl)
                    begin
                        perr_next = lrp_pkg::ERR_OVERFLOW;
                    end
                    else if (kl + acc_or != rem64)
                    begin
                        perr_next = lrp_pkg::ERR_TRAILING;
                    end
                end
                acc_next = '0;
                sh_next = '0;
            end
            else
            begin
                sh_next = sh_add;
                if (sh_add > 7'd63)
                begin
                    perr_next = (ph_reg == lrp_pkg::PH_KEY) ? lrp_pkg::ERR_KEY_VARINT
                                                           : lrp_pkg::ERR_VALUE_VARINT;
                    ph_next = lrp_pkg::PH_SKIP;
                end
            end
        end
        else if (ph_reg == lrp_pkg::PH_PAYLOAD)
        begin
            if (acc_reg < kl_cur)
            begin
                ra = mk(lrp_pkg::KIND_KEY, b, lrp_pkg::ERR_NONE);
                n = 2'd1;
            end
            else if (acc_reg - kl_cur < vc_reg)
            begin
                ra = mk(lrp_pkg::KIND_VALUE, b, lrp_pkg::ERR_NONE);
                n = 2'd1;
            end
            acc_next = acc_reg + 64'd1;
        end

        if (pos_reg < 33'd24)
        begin
            if (eob)
            begin
                code = lrp_pkg::ERR_HEADER_TRUNC;
            end
        end
        else if (pos_reg == 33'd24 && len_reg < lrp_pkg::MIN_LENGTH)
        begin
            code = lrp_pkg::ERR_TOO_SHORT;
        end
        else if (pos_reg == 33'd24 && len_reg > max_len)
        begin
            code = lrp_pkg::ERR_TOO_LONG;
        end
        else if (endrec)
        begin
            if (check_crc && scrc_reg != ~rcrc_next)
            begin
                code = lrp_pkg::ERR_CRC;
            end
            else if (perr_next != lrp_pkg::ERR_NONE)
            begin
                code = perr_next;
            end
            else if (ph_next != lrp_pkg::PH_PAYLOAD)
            begin
                code = lrp_pkg::ERR_OVERFLOW;
            end
            if (code == lrp_pkg::ERR_NONE)
            begin
                rb = mk(lrp_pkg::KIND_SUMMARY, 8'd0, lrp_pkg::ERR_NONE);
                rb.record_offset = off_next;
                rb.record_timestamp = ts_next;
                rb.attribute_bits = attr_next;
                rb.key_absent = (key_next == 64'd0);
                rb.key_length = (key_next == 64'd0) ? 32'd0 : key_next[31:0] - 32'd1;
                rb.value_length = vc_next[31:0];
            end
        end
        else if (eob)
        begin
            code = lrp_pkg::ERR_RECORD_TRUNC;
        end

        if (code != lrp_pkg::ERR_NONE)
        begin
            rb = mk(lrp_pkg::KIND_ERROR, 8'd0, code);
            stop_next = 1'b1;
            perr_next = code;
        end
        if (code != lrp_pkg::ERR_NONE || (endrec && pos_reg >= 33'd24))
        begin
            if (n == 2'd0)
            begin
                ra = rb;
                n = 2'd1;
            end
            else
            begin
                n = 2'd2;
            end
        end
        if (n == 2'd1)
        begin
            ra.last = 1'b1;
        end
        else if (n == 2'd2)
        begin
            rb.last = 1'b1;
        end

        if (!stop_next && !(endrec && pos_reg >= 33'd24))
        begin
            pos_next = pos_reg + 33'd1;
        end
        if (code == lrp_pkg::ERR_NONE && endrec && pos_reg >= 33'd24)
        begin
            pos_next = '0;
            len_next = '0;
            scrc_next = '0;
            rcrc_next = '1;
            off_next = '0;
            ts_next = '0;
            attr_next = '0;
            acc_next = '0;
            sh_next = '0;
            ph_next = lrp_pkg::PH_KEY;
            key_next = '0;
            vc_next = '0;
            perr_next = '0;
        end
    end

    assign res_count = (in_fire && !stop_reg) ? n : 2'd0;
    assign res_a = ra;
    assign res_b = rb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            len_reg <= '0;
            scrc_reg <= '0;
            rcrc_reg <= '1;
            off_reg <= '0;
            ts_reg <= '0;
            attr_reg <= '0;
            acc_reg <= '0;
            sh_reg <= '0;
            ph_reg <= lrp_pkg::PH_KEY;
            key_reg <= '0;
            vc_reg <= '0;
            perr_reg <= '0;
            stop_reg <= 1'b0;
        end
        else if (in_fire && !stop_reg)
        begin
            pos_reg <= pos_next;
            len_reg <= len_next;
            scrc_reg <= scrc_next;
            rcrc_reg <= rcrc_next;
            off_reg <= off_next;
            ts_reg <= ts_next;
            attr_reg <= attr_next;
            acc_reg <= acc_next;
            sh_reg <= sh_next;
            ph_reg <= ph_next;
            key_reg <= key_next;
            vc_reg <= vc_next;
            perr_reg <= perr_next;
            stop_reg <= stop_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |=> stop_reg)
        else $error("stop released");
    assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |-> res_count == 2'd0)
        else $error("result after stop");
    assert property (@(posedge clk) disable iff (!rst_n)
        res_count == 2'd2 |-> res_b.kind == lrp_pkg::KIND_SUMMARY
                           || res_b.kind == lrp_pkg::KIND_ERROR)
        else $error("second result kind");

endmodule

### hw/rtl/log_record_parser.sv
// Byte-serial deframer for length-prefixed log records: one byte is taken per clock while the
// output queue has room for two results, each byte yields at most a payload byte and a record
// summary or latched error, and results leave in order through a four-entry queue so bytes keep
// flowing while results wait; after any error the input is drained with no further results.
module log_record_parser
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,    // data_byte
    input  logic          s_tlast,    // end_of_buffer
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [215:0]  m_tdata,    // payload_byte, record_offset, record_timestamp,
                                      // attribute_bits, key_absent, key_length,
                                      // value_length, error_code, zero fill
    output logic [1:0]    m_tuser,    // result_kind
    output logic          m_tlast,    // last
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_data
);

    logic check_crc_reg;
    logic [31:0] max_len_reg;
    logic in_fire;
    logic space_ok;
    logic stopped;
    logic [1:0] res_count;
    lrp_pkg::result_t res_a, res_b, q_item;

    assign cfg_ready = 1'b1;
    assign s_tready = space_ok || stopped;
    assign in_fire = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_crc_reg <= lrp_pkg::CHECK_CRC_RESET;
            max_len_reg <= lrp_pkg::MAX_LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == lrp_pkg::CFG_CHECK_CRC)
            begin
                check_crc_reg <= cfg_data[0];
            end
            else
            begin
                max_len_reg <= cfg_data;
            end
        end
    end

    lrp_parse_core u_core
    (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .b(s_tdata), .eob(s_tlast),
        .check_crc(check_crc_reg), .max_len(max_len_reg), .stopped(stopped),
        .res_count(res_count), .res_a(res_a), .res_b(res_b)
    );

    lrp_out_queue u_queue
    (
        .clk(clk), .rst_n(rst_n), .push(in_fire), .push_count(res_count),
        .push_a(res_a), .push_b(res_b), .space_ok(space_ok),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_item(q_item)
    );

    assign m_tuser = q_item.kind;
    assign m_tlast = q_item.last;
    assign m_tdata = {3'd0, q_item.error_code, q_item.value_length, q_item.key_length,
                      q_item.key_absent, q_item.attribute_bits, q_item.record_timestamp,
                      q_item.record_offset, q_item.payload_byte};

endmodule
